>>> hdl/mi3_pkg.sv
// Shared types, widths and the cofactor table for the 3x3 matrix inverse.
// No dependencies; every other file imports this package.
package mi3_pkg;

    localparam int EW     = 32;              // element width
    localparam int FB     = 16;              // fraction bits
    localparam int THR_W  = 31;              // threshold register width
    localparam int ADJ_W  = 2 * EW + 1;      // signed adjugate entry
    localparam int AM_W   = 2 * EW;          // adjugate magnitude
    localparam int PP_W   = 2 * EW + 1;      // det partial product
    localparam int TRM_W  = 3 * EW + 2;      // one det term
    localparam int DET_W  = 3 * EW + 3;      // signed determinant
    localparam int DM_W   = 3 * EW;          // determinant magnitude
    localparam int QB     = EW + 2;          // quotient bits of 2N/D
    localparam int NW     = AM_W + 2 * FB + 1; // remainder width (2N)
    localparam int CW     = DM_W + QB;       // compare width in the divider
    localparam int PRE_ST = 6;               // products .. det magnitude
    localparam int DIV_ST = QB + 2;          // init, one per bit, round/clamp
    localparam int NST    = PRE_ST + DIV_ST;

    typedef logic signed [EW-1:0]    elem_t;
    typedef logic signed [ADJ_W-1:0] adj_t;
    typedef logic [AM_W-1:0]         amag_t;
    typedef logic [DM_W-1:0]         dmag_t;

    typedef struct packed {
        logic signed [EW-1:0] a00;
        logic signed [EW-1:0] a01;
        logic signed [EW-1:0] a02;
        logic signed [EW-1:0] a10;
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a20;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
    } mat_t;

    typedef struct packed {
        logic signed [EW-1:0] r00;
        logic signed [EW-1:0] r01;
        logic signed [EW-1:0] r02;
        logic signed [EW-1:0] r10;
        logic signed [EW-1:0] r11;
        logic signed [EW-1:0] r12;
        logic signed [EW-1:0] r20;
        logic signed [EW-1:0] r21;
        logic signed [EW-1:0] r22;
        logic                 singular;
        logic                 saturated;
    } inv_t;

    typedef struct packed {
        elem_t val;
        logic  sat;
        logic  sing;
    } res_elem_t;

    // adjugate entry k = a[p]*a[q] - a[r]*a[s], row-major element indexes
    localparam logic [3:0] ADJ_TERMS [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

>>> hdl/mi3_adj.sv
// Adjugate stages: 18 element products, then nine cofactor differences.
// Depends on mi3_pkg.
module mi3_adj
    import mi3_pkg::*;
(
    input  logic        clk,
    input  logic [1:0]  en,
    input  elem_t [8:0] a,
    output adj_t  [8:0] adj,
    output elem_t [8:0] a_d
);

    logic signed [2*EW-1:0] p_reg [9][2];
    elem_t [8:0] a0_reg;
    elem_t [8:0] a1_reg;
    adj_t  [8:0] adj_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a0_reg <= a;
            for (int k = 0; k < 9; k++)
            begin
                p_reg[k][0] <= a[ADJ_TERMS[k][0]] * a[ADJ_TERMS[k][1]];
                p_reg[k][1] <= a[ADJ_TERMS[k][2]] * a[ADJ_TERMS[k][3]];
            end
        end
        if (en[1])
        begin
            a1_reg <= a0_reg;
            for (int k = 0; k < 9; k++)
                adj_reg[k] <= ADJ_W'(p_reg[k][0]) - ADJ_W'(p_reg[k][1]);
        end
    end

    assign adj = adj_reg;
    assign a_d = a1_reg;

endmodule

>>> hdl/mi3_det.sv
// Determinant stages: split 32x65 products, term sums, magnitude and
// singular test. Depends on mi3_pkg.
module mi3_det
    import mi3_pkg::*;
(
    input  logic              clk,
    input  logic [3:0]        en,
    input  logic [THR_W-1:0]  thr,
    input  adj_t  [8:0]       adj,
    input  elem_t [8:0]       a,
    output amag_t [8:0]       amag,
    output logic  [8:0]       neg,
    output dmag_t             dmag,
    output logic              sing,
    output elem_t [8:0]       a_d
);

    logic signed [PP_W-1:0]  lo_reg [3];
    logic signed [PP_W-1:0]  hi_reg [3];
    logic signed [TRM_W-1:0] t_reg [3];
    logic signed [DET_W-1:0] det_reg;
    logic signed [DET_W-1:0] det_abs;
    adj_t  [8:0] adj_reg [3];
    elem_t [8:0] a_reg [4];
    amag_t [8:0] amag_reg;
    logic  [8:0] neg_reg;
    dmag_t       dmag_reg;
    logic        sing_reg;

    assign det_abs = det_reg[DET_W-1] ? -det_reg : det_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            adj_reg[0] <= adj;
            a_reg[0]   <= a;
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= a[j] * $signed({1'b0, adj[3*j][EW-1:0]});
                hi_reg[j] <= a[j] * $signed(adj[3*j][ADJ_W-1:EW]);
            end
        end
        if (en[1])
        begin
            adj_reg[1] <= adj_reg[0];
            a_reg[1]   <= a_reg[0];
            for (int j = 0; j < 3; j++)
                t_reg[j] <= (TRM_W'(hi_reg[j]) <<< EW) + TRM_W'(lo_reg[j]);
        end
        if (en[2])
        begin
            adj_reg[2] <= adj_reg[1];
            a_reg[2]   <= a_reg[1];
            det_reg    <= DET_W'(t_reg[0]) + DET_W'(t_reg[1]) + DET_W'(t_reg[2]);
        end
        if (en[3])
        begin
            a_reg[3] <= a_reg[2];
            dmag_reg <= det_abs[DM_W-1:0];
            sing_reg <= (det_reg == '0) ||
                        (det_abs[DM_W-1:0] < DM_W'({thr, {(2*FB){1'b0}}}));
            for (int k = 0; k < 9; k++)
            begin
                amag_reg[k] <= adj_reg[2][k][ADJ_W-1] ? AM_W'(-adj_reg[2][k])
                                                      : AM_W'(adj_reg[2][k]);
                neg_reg[k]  <= adj_reg[2][k][ADJ_W-1] ^ det_reg[DET_W-1];
            end
        end
    end

    assign amag = amag_reg;
    assign neg  = neg_reg;
    assign dmag = dmag_reg;
    assign sing = sing_reg;
    assign a_d  = a_reg[3];

endmodule

>>> hdl/mi3_div.sv
// Pipelined restoring divider for one element: one quotient bit per stage,
// then round to nearest and clamp. Depends on mi3_pkg.
module mi3_div
    import mi3_pkg::*;
(
    input  logic              clk,
    input  logic [DIV_ST-1:0] en,
    input  amag_t             amag,
    input  dmag_t             dmag,
    input  logic              neg,
    input  logic              sing,
    input  elem_t             byp,
    output res_elem_t         res
);

    logic [NW-1:0] r_reg   [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    dmag_t         d_reg   [QB+1];
    logic          ovf_reg [QB+1];
    logic          neg_reg [QB+1];
    logic          sing_reg[QB+1];
    elem_t         byp_reg [QB+1];
    res_elem_t     res_reg;
    res_elem_t     res_next;

    logic [NW-1:0] r0;
    assign r0 = {amag, {(2*FB+1){1'b0}}};   // 2N

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]    <= r0;
            q_reg[0]    <= '0;
            d_reg[0]    <= dmag;
            ovf_reg[0]  <= CW'(r0) >= (CW'(dmag) << QB);
            neg_reg[0]  <= neg;
            sing_reg[0] <= sing;
            byp_reg[0]  <= byp;
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_bit
        logic [CW-1:0] dsh;
        logic          ge;
        logic [QB-1:0] q_set;
        assign dsh   = CW'(d_reg[s-1]) << (QB - s);
        assign ge    = CW'(r_reg[s-1]) >= dsh;
        assign q_set = QB'(1) << (QB - s);

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                r_reg[s]    <= ge ? r_reg[s-1] - NW'(dsh) : r_reg[s-1];
                q_reg[s]    <= ge ? (q_reg[s-1] | q_set) : q_reg[s-1];
                d_reg[s]    <= d_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
                byp_reg[s]  <= byp_reg[s-1];
            end
        end
    end

    // round half away: q = (floor(2N/D) + 1) / 2
    logic [QB:0]   qr;
    logic [QB-1:0] q;
    logic          negr;
    logic          sat;
    assign qr   = (QB+1)'(q_reg[QB]) + (QB+1)'(1);
    assign q    = qr[QB:1];
    assign negr = neg_reg[QB] && ((q != '0) || ovf_reg[QB]);
    assign sat  = ovf_reg[QB] ||
                  (negr ? (q > (QB'(1) << (EW - 1)))
                        : (q > ((QB'(1) << (EW - 1)) - QB'(1))));

    always_comb
    begin
        res_next.sing = sing_reg[QB];
        if (sing_reg[QB])
        begin
            res_next.val = byp_reg[QB];
            res_next.sat = 1'b0;
        end
        else
        begin
            res_next.sat = sat;
            if (sat)
                res_next.val = negr ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
            else
                res_next.val = negr ? -q[EW-1:0] : q[EW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV_ST-1])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

>>> hdl/matrix3x3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse.
// Depends on mi3_pkg, mi3_adj, mi3_det and mi3_div.
//
// Usage:
//   mat channel   : one 3x3 Q16.16 matrix per beat (mat_valid / mat_stall).
//   inv channel   : the inverse, plus singular and saturated flags, one beat
//                   per input beat, in order (inv_valid / inv_stall).
//   cfg channel   : writes singular_threshold (31 bits); cfg_ready is always
//                   high. Write only while the block holds no item.
// Throughput: one matrix per cycle while the output is not stalled. Every
//   stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles collapse and a new beat is taken
//   while a finished result still waits.
// Depth: NST = 42 register stages: 2 adjugate stages, 4 determinant
//   stages (split 32x65 products, term sums, magnitude and singular test),
//   and a 36-stage divider, one quotient bit per stage plus init and
//   round/clamp. The 9 dividers run in parallel; the quotient bit loop
//   sets the depth.
// Reset: all valid bits clear, the threshold returns to 1.
// Stall: a stalled result holds in the output stage; the pipe keeps filling
//   behind it and mat_stall rises only once every stage is occupied.
module matrix3x3_inverse
    import mi3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mat_valid,
    output logic             mat_stall,
    input  mat_t             mat,
    output logic             inv_valid,
    input  logic             inv_stall,
    output inv_t             inv,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   en;
    logic [THR_W-1:0] thr_reg;

    elem_t [8:0] a_in;
    adj_t  [8:0] adj;
    elem_t [8:0] a_s1;
    amag_t [8:0] amag;
    logic  [8:0] neg;
    dmag_t       dmag;
    logic        sing;
    elem_t [8:0] a_s5;
    res_elem_t [8:0] res;

    // stage loads when empty or when its successor moves
    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || !inv_stall;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            thr_reg <= THR_W'(1);
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= mat_valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
        end
    end

    assign mat_stall = !en[0];
    assign inv_valid = vld_reg[NST-1];
    assign cfg_ready = 1'b1;

    assign a_in = {mat.a22, mat.a21, mat.a20, mat.a12, mat.a11, mat.a10,
                   mat.a02, mat.a01, mat.a00};

    mi3_adj u_adj (
        .clk (clk),
        .en  (en[1:0]),
        .a   (a_in),
        .adj (adj),
        .a_d (a_s1)
    );

    mi3_det u_det (
        .clk  (clk),
        .en   (en[5:2]),
        .thr  (thr_reg),
        .adj  (adj),
        .a    (a_s1),
        .amag (amag),
        .neg  (neg),
        .dmag (dmag),
        .sing (sing),
        .a_d  (a_s5)
    );

    for (genvar k = 0; k < 9; k++)
    begin : g_div
        mi3_div u_div (
            .clk  (clk),
            .en   (en[NST-1:PRE_ST]),
            .amag (amag[k]),
            .dmag (dmag),
            .neg  (neg[k]),
            .sing (sing),
            .byp  (a_s5[k]),
            .res  (res[k])
        );
    end

    always_comb
    begin
        inv.r00       = res[0].val;
        inv.r01       = res[1].val;
        inv.r02       = res[2].val;
        inv.r10       = res[3].val;
        inv.r11       = res[4].val;
        inv.r12       = res[5].val;
        inv.r20       = res[6].val;
        inv.r21       = res[7].val;
        inv.r22       = res[8].val;
        inv.singular  = res[0].sing;
        inv.saturated = res[0].sat | res[1].sat | res[2].sat | res[3].sat |
                        res[4].sat | res[5].sat | res[6].sat | res[7].sat |
                        res[8].sat;
    end

    // a singular beat never reports saturation
    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid |-> !(inv.singular && inv.saturated))
        else $error("singular result flagged saturated");

    // first stage empty means the input side is open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> !mat_stall)
        else $error("input stalled with empty first stage");

    // an unstalled output always drains the last stage
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_valid && !inv_stall && !vld_reg[NST-2]) |=> !inv_valid)
        else $error("output beat repeated");

endmodule

>>> tb/matrix3x3_inverse_tb.sv
// Self-checking testbench for matrix3x3_inverse: drives random and corner-case matrices
// and compares each result beat against an exact inverse predictor in a scoreboard class.
// Depends on mi3_pkg and the matrix3x3_inverse RTL.
module matrix3x3_inverse_tb;
    import mi3_pkg::*;

    localparam int WIDE      = 200;   // room for |adj| << 32 and the full determinant
    localparam int DRAIN_CYC = 60;    // a bit more than the 42-stage pipe depth
    localparam int WD_LIMIT  = 4000;  // idle cycles before the watchdog fires
    localparam int PHASE_N   = 340;   // random beats per threshold setting

    typedef logic signed [WIDE-1:0] wide_t;

    // Expected inverse beats in issue order, plus the exact predictor.
    class inv_scoreboard;
        inv_t             pending_q[$];
        logic [THR_W-1:0] thresh;
        int               errors;

        function new();
            thresh = 1;
            errors = 0;
        endfunction

        // Exact cofactor inverse with round-half-away and clamp to element range.
        function inv_t predict(mat_t m);
            wide_t            a[9];
            wide_t            adj[9];
            wide_t            det, dmag, num, quo, rem, lim, bound;
            logic signed [EW-1:0] res[9];
            logic             neg, sat;
            inv_t             r;
            for (int k = 0; k < 9; k++)
            begin
                a[k] = wide_t'($signed(m[(8-k)*EW +: EW]));
            end
            for (int k = 0; k < 9; k++)
            begin
                adj[k] = a[ADJ_TERMS[k][0]] * a[ADJ_TERMS[k][1]]
                       - a[ADJ_TERMS[k][2]] * a[ADJ_TERMS[k][3]];
            end
            det  = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
            dmag = (det < 0) ? -det : det;
            lim  = wide_t'(thresh) <<< (2 * FB);
            r = '0;
            if (det == 0 || dmag < lim)
            begin
                // singular: matrix passes through untouched
                for (int k = 0; k < 9; k++)
                begin
                    r[2+(8-k)*EW +: EW] = m[(8-k)*EW +: EW];
                end
                r.singular = 1'b1;
                return r;
            end
            sat = 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                num = ((adj[k] < 0) ? -adj[k] : adj[k]) <<< (2 * FB);
                quo = num / dmag;
                rem = num % dmag;
                if ((rem <<< 1) >= dmag)
                begin
                    quo = quo + 1;
                end
                neg   = ((adj[k] < 0) != (det < 0)) && (quo != 0);
                bound = neg ? (wide_t'(1) <<< (EW-1)) : ((wide_t'(1) <<< (EW-1)) - 1);
                if (quo > bound)
                begin
                    quo = bound;
                    sat = 1'b1;
                end
                res[k] = neg ? -quo[EW-1:0] : quo[EW-1:0];
                r[2+(8-k)*EW +: EW] = res[k];
            end
            r.saturated = sat;
            return r;
        endfunction

        function void note_input(mat_t m);
            pending_q.push_back(predict(m));
        endfunction

        function void check_result(inv_t got);
            inv_t exp_r;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            exp_r = pending_q.pop_front();
            for (int k = 0; k < 9; k++)
            begin
                if (got[2+(8-k)*EW +: EW] !== exp_r[2+(8-k)*EW +: EW])
                begin
                    errors++;
                    $display("%0t: r%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                             exp_r[2+(8-k)*EW +: EW], got[2+(8-k)*EW +: EW]);
                end
            end
            if (got.singular !== exp_r.singular)
            begin
                errors++;
                $display("%0t: singular expected %b actual %b", $time,
                         exp_r.singular, got.singular);
            end
            if (got.saturated !== exp_r.saturated)
            begin
                errors++;
                $display("%0t: saturated expected %b actual %b", $time,
                         exp_r.saturated, got.saturated);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             mat_valid;
    logic             mat_stall;
    mat_t             mat;
    logic             inv_valid;
    logic             inv_stall;
    inv_t             inv;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;

    inv_scoreboard sb;
    int            idle_cycles;
    int            stall_mode;
    int            stall_left;

    matrix3x3_inverse i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .inv_valid (inv_valid),
        .inv_stall (inv_stall),
        .inv       (inv),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Output side: check accepted beats, drive the stall pattern, run the watchdog.
    // Signals sampled right after the edge still hold their pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((inv_valid && !inv_stall) || (mat_valid && !mat_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (inv_valid && !inv_stall)
                sb.check_result(inv);
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        // stall modes: none, light, heavy; each held for a random stretch
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       inv_stall <= 1'b0;
            1:       inv_stall <= ($urandom_range(0, 3) == 0);
            default: inv_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // One matrix beat; valid stays high across back-to-back beats.
    task automatic send_mat(mat_t m);
        mat_valid <= 1'b1;
        mat       <= m;
        do
            @(posedge clk);
        while (mat_stall);
        sb.note_input(m);
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            mat_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Wait out every expected beat plus the pipe depth, then write the threshold.
    task automatic write_thresh(logic [THR_W-1:0] v);
        idle_sender(1);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.thresh = v;
    endtask

    function automatic elem_t small_elem(int span);
        return elem_t'($urandom_range(0, 2 * span)) - elem_t'(span);
    endfunction

    function automatic elem_t corner_elem();
        case ($urandom_range(0, 6))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0001_0000;
            3:       return -32'sh0001_0000;
            4:       return 32'sh0000_0001;
            5:       return 0;
            default: return elem_t'($urandom());
        endcase
    endfunction

    function automatic mat_t diag(elem_t d);
        mat_t m;
        m = '0;
        m.a00 = d;
        m.a11 = d;
        m.a22 = d;
        return m;
    endfunction

    function automatic mat_t rand_mat();
        mat_t  m;
        elem_t e[9];
        int    kind;
        int    span;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(8, 20);
        for (int k = 0; k < 9; k++)
        begin
            case (kind)
                0, 1:    e[k] = elem_t'($urandom());
                9:       e[k] = corner_elem();
                default: e[k] = small_elem(span);
            endcase
        end
        if (kind == 6 || kind == 7)
        begin
            // diagonally dominant: well conditioned
            e[0] += elem_t'(4 * span);
            e[4] -= elem_t'(4 * span);
            e[8] += elem_t'(4 * span);
        end
        if (kind == 8)
        begin
            // row 2 = row 0 + row 1, with a little noise half the time
            for (int c = 0; c < 3; c++)
                e[6+c] = e[c] + e[3+c] + (($urandom_range(0, 1) == 1) ? small_elem(2) : 0);
        end
        for (int k = 0; k < 9; k++)
            m[(8-k)*EW +: EW] = e[k];
        return m;
    endfunction

    task automatic random_phase(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 20));
            end
            burst--;
            send_mat(rand_mat());
        end
    endtask

    initial
    begin
        mat_t m;
        sb          = new();
        idle_cycles = 0;
        stall_mode  = 0;
        stall_left  = 0;
        rst_n       = 1'b0;
        mat_valid   = 1'b0;
        mat         = '0;
        inv_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, zero, scaled diagonals, extremes, rank deficiency
        send_mat(diag(32'sh0001_0000));
        send_mat('0);
        send_mat(diag(32'sh0000_0001));         // det tiny: singular at reset threshold
        send_mat(diag(32'sh0000_0100));         // det below reset threshold: singular
        send_mat(diag(-32'sh0000_0100));        // det magnitude below reset threshold: singular
        send_mat(diag(32'sh7fff_ffff));
        send_mat(diag(32'sh8000_0000));
        send_mat(diag(32'sh0003_0000));         // 1/3: rounding
        send_mat(diag(32'sh0002_0000));
        send_mat({9{32'sh7fff_ffff}});
        send_mat({9{32'sh8000_0000}});
        send_mat({9{32'shffff_ffff}});
        m = '0;
        m.a02 = 32'sh0001_0000;
        m.a11 = 32'sh0002_0000;
        m.a20 = -32'sh0004_0000;
        send_mat(m);                             // anti-diagonal
        m = rand_mat();
        m.a20 = m.a00;
        m.a21 = m.a01;
        m.a22 = m.a02;
        send_mat(m);                             // two equal rows
        for (int i = 0; i < 6; i++)
            send_mat(rand_mat());

        // threshold 0: only exact zero determinant is singular
        write_thresh('0);
        send_mat('0);
        send_mat(diag(32'sh0000_0001));
        random_phase(PHASE_N);

        write_thresh(31'h7fff_ffff);             // nearly everything singular
        send_mat(diag(32'sh7fff_ffff));
        random_phase(PHASE_N);

        write_thresh(31'd1);
        random_phase(PHASE_N);

        write_thresh(31'h0001_0000);
        random_phase(PHASE_N);

        // hold off until the pipe is empty, then resume
        idle_sender(1);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        random_phase(PHASE_N / 2);

        write_thresh(THR_W'($urandom_range(0, 1 << 12)));
        random_phase(PHASE_N);

        idle_sender(1);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
